### rtl/ogru_pkg.sv
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types, constants and the sine helper of the occupancy grid ray update.
// ----------------------------------------------------------------------------
package ogru_pkg;

	// grid size defaults
	localparam int GRID_WIDTH_DEF  = 1024;
	localparam int GRID_HEIGHT_DEF = 1024;

	// cell codes
	localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
	localparam logic [1:0] CELL_FREE     = 2'd1;
	localparam logic [1:0] CELL_OCCUPIED = 2'd2;

	// half size of the free square at the grid center
	localparam int FREE_HALF = 10;
	// range margin below the maximum for an endpoint hit
	localparam logic [16:0] MARGIN_MM = 17'd100;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CELLS_PER_MM = 3'd0,
		REG_ROBOT_X      = 3'd1,
		REG_ROBOT_Y      = 3'd2,
		REG_HEADING      = 3'd3,
		REG_ANGLE_START  = 3'd4,
		REG_ANGLE_STEP   = 3'd5,
		REG_RANGE_MIN    = 3'd6,
		REG_RANGE_MAX    = 3'd7
	} cfg_reg_t;

	// configuration reset values
	localparam logic [15:0] RST_CELLS_PER_MM = 16'd1311;
	localparam logic [15:0] RST_ROBOT_X      = 16'd25000;
	localparam logic [15:0] RST_ROBOT_Y      = 16'd25000;
	localparam logic [15:0] RST_HEADING      = 16'd0;
	localparam logic [15:0] RST_ANGLE_START  = 16'd0;
	localparam logic [15:0] RST_ANGLE_STEP   = 16'd182;
	localparam logic [15:0] RST_RANGE_MIN    = 16'd100;
	localparam logic [15:0] RST_RANGE_MAX    = 16'd10000;

	// cell coordinates and line error term
	localparam int CELL_W = 20;
	localparam int ERR_W  = 23;
	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic signed [ERR_W-1:0]  err_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       angle;
		logic       sine;
		logic       endpt;
		logic       conv;
		logic [1:0] conv_sel;
		logic       init;
		logic       walk;
		logic       mark;
		logic       read;
		logic       clear;
		logic       out_load;
	} ogru_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_read;
		logic ray_ok;
		logic at_end;
		logic clear_last;
	} ogru_sts_t;

	// quarter-wave sine table, Q14
	localparam logic [14:0] SINE_Q14 [33] = '{
		15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
		15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
		15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
		15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
		15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
	};

	// sine of a binary angle in Q14, table with rounded linear interpolation
	function automatic logic signed [15:0] sine_bam(input logic [15:0] a);
		logic [14:0] p;
		logic [5:0]  idx;
		logic [8:0]  frac;
		logic [14:0] d;
		logic [19:0] prod;
		logic [14:0] v;
		p    = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		idx  = p[14:9];
		frac = p[8:0];
		if (idx >= 6'd32) begin
			v = 15'd16384;
		end else begin
			d    = SINE_Q14[idx + 6'd1] - SINE_Q14[idx];
			prod = 20'(d[9:0]) * 20'(frac) + 20'd256;
			v    = SINE_Q14[idx] + 15'(prod[19:9]);
		end
		return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

### rtl/ogru_item_if.sv
// ----------------------------------------------------------------------------
// ogru_item_if
// Input channel: one ray or one cell read per transaction.
// ----------------------------------------------------------------------------
interface ogru_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [11:0] beam_index;
	logic [15:0] range_mm;
	logic        range_valid;
	logic [9:0]  read_x;
	logic [9:0]  read_y;

	modport source (output valid, func, beam_index, range_mm, range_valid, read_x, read_y,
		input ready);
	modport sink (input valid, func, beam_index, range_mm, range_valid, read_x, read_y,
		output ready);
endinterface

### rtl/ogru_result_if.sv
// ----------------------------------------------------------------------------
// ogru_result_if
// Output channel: one result per transaction.
// ----------------------------------------------------------------------------
interface ogru_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] cell_value;
	logic       ray_used;
	logic       endpoint_marked;

	modport source (output valid, cell_value, ray_used, endpoint_marked, input ready);
	modport sink (input valid, cell_value, ray_used, endpoint_marked, output ready);
endinterface

### rtl/occupancy_grid_ray_update.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Two-bit occupancy grid updated by laser rays along Bresenham lines.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory once, one cell a cycle,
// writing unknown everywhere and free in the 21x21 square at the center; no
// transaction is accepted during the sweep. It then handles one item at a
// time: a cell read, a skipped ray, or a used ray whose line goes through
// the line walker that does one read-modify-write of the grid memory per
// cycle. The result sits in an output register; the next item is taken once
// it has been loaded there, so a result that is not taken stalls the input.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update #(
	parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ogru_item_if.sink     item,
	ogru_result_if.source result,
	input logic           wr_en,
	input logic [2:0]     wr_index,
	input logic [15:0]    wr_data
);

	ogru_pkg::ogru_cmd_t cmd;
	ogru_pkg::ogru_sts_t sts;

	// sequencer
	ogru_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// arithmetic, walker and grid memory
	ogru_datapath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.func            (item.func),
		.beam_index      (item.beam_index),
		.range_mm        (item.range_mm),
		.range_valid     (item.range_valid),
		.read_x          (item.read_x),
		.read_y          (item.read_y),
		.cmd             (cmd),
		.sts             (sts),
		.cell_value      (result.cell_value),
		.ray_used        (result.ray_used),
		.endpoint_marked (result.endpoint_marked)
	);

endmodule

### rtl/ogru_datapath.sv
// ----------------------------------------------------------------------------
// ogru_datapath
// Configuration, endpoint math, line walker and the grid memory.
// ----------------------------------------------------------------------------
module ogru_datapath #(
	parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [15:0]         wr_data,
	input  logic                func,
	input  logic [11:0]         beam_index,
	input  logic [15:0]         range_mm,
	input  logic                range_valid,
	input  logic [9:0]          read_x,
	input  logic [9:0]          read_y,
	input  ogru_pkg::ogru_cmd_t cmd,
	output ogru_pkg::ogru_sts_t sts,
	output logic [1:0]          cell_value,
	output logic                ray_used,
	output logic                endpoint_marked
);

	localparam int XW    = $clog2(GRID_WIDTH);
	localparam int YW    = $clog2(GRID_HEIGHT);
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = ogru_pkg::CELL_W;
	localparam int EW    = ogru_pkg::ERR_W;
	localparam int FX_LO = GRID_WIDTH / 2 - ogru_pkg::FREE_HALF;
	localparam int FX_HI = GRID_WIDTH / 2 + ogru_pkg::FREE_HALF;
	localparam int FY_LO = GRID_HEIGHT / 2 - ogru_pkg::FREE_HALF;
	localparam int FY_HI = GRID_HEIGHT / 2 + ogru_pkg::FREE_HALF;

	// configuration registers
	logic [15:0] cpm_q, rx_mm_q, ry_mm_q, heading_q, a_start_q, a_step_q, rmin_q, rmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q     <= ogru_pkg::RST_CELLS_PER_MM;
			rx_mm_q   <= ogru_pkg::RST_ROBOT_X;
			ry_mm_q   <= ogru_pkg::RST_ROBOT_Y;
			heading_q <= ogru_pkg::RST_HEADING;
			a_start_q <= ogru_pkg::RST_ANGLE_START;
			a_step_q  <= ogru_pkg::RST_ANGLE_STEP;
			rmin_q    <= ogru_pkg::RST_RANGE_MIN;
			rmax_q    <= ogru_pkg::RST_RANGE_MAX;
		end else if (wr_en) begin
			case (ogru_pkg::cfg_reg_t'(wr_index))
				ogru_pkg::REG_CELLS_PER_MM: cpm_q     <= wr_data;
				ogru_pkg::REG_ROBOT_X:      rx_mm_q   <= wr_data;
				ogru_pkg::REG_ROBOT_Y:      ry_mm_q   <= wr_data;
				ogru_pkg::REG_HEADING:      heading_q <= wr_data;
				ogru_pkg::REG_ANGLE_START:  a_start_q <= wr_data;
				ogru_pkg::REG_ANGLE_STEP:   a_step_q  <= wr_data;
				ogru_pkg::REG_RANGE_MIN:    rmin_q    <= wr_data;
				ogru_pkg::REG_RANGE_MAX:    rmax_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// latched item
	logic        func_q;
	logic [11:0] beam_q;
	logic [15:0] range_q;
	logic        rvalid_q;
	logic [9:0]  rdx_q, rdy_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			beam_q   <= beam_index;
			range_q  <= range_mm;
			rvalid_q <= range_valid;
			rdx_q    <= read_x;
			rdy_q    <= read_y;
		end
	end

	logic ray_ok;
	assign ray_ok = rvalid_q && (range_q >= rmin_q) && (range_q <= rmax_q);

	// angle, sine and endpoint
	logic [15:0]        ang_q;
	logic signed [15:0] cos_q, sin_q;
	logic signed [33:0] ex_q, ey_q, px, py;
	logic signed [32:0] prod_cx, prod_sy;
	logic [27:0]        beam_ang;

	assign beam_ang = beam_q * a_step_q;
	assign px       = $signed({2'b00, rx_mm_q, 14'd0});
	assign py       = $signed({2'b00, ry_mm_q, 14'd0});
	assign prod_cx  = $signed({1'b0, range_q}) * cos_q;
	assign prod_sy  = $signed({1'b0, range_q}) * sin_q;

	always_ff @(posedge clk) begin
		if (cmd.angle)
			ang_q <= heading_q + a_start_q + beam_ang[15:0];
		if (cmd.sine) begin
			cos_q <= ogru_pkg::sine_bam(ang_q + 16'h4000);
			sin_q <= ogru_pkg::sine_bam(ang_q);
		end
		if (cmd.endpt) begin
			ex_q <= px + 34'(prod_cx);
			ey_q <= py + 34'(prod_sy);
		end
	end

	// millimetre to cell conversion, multiply then round stage
	logic signed [33:0] conv_e;
	logic [33:0]        conv_mag;
	logic [47:0]        prod_s1;
	logic               neg_s1;
	logic [1:0]         sel_s1;
	logic               conv_s1;
	logic [48:0]        rnd;
	ogru_pkg::cell_t    conv_cell;

	always_comb begin
		case (cmd.conv_sel)
			2'd0:    conv_e = px;
			2'd1:    conv_e = py;
			2'd2:    conv_e = ex_q;
			default: conv_e = ey_q;
		endcase
		conv_mag = conv_e[33] ? 34'(-conv_e) : 34'(conv_e);
		rnd      = {1'b0, prod_s1} + 49'h0_3FFF_FFFF;
		conv_cell = neg_s1 ? -ogru_pkg::cell_t'({1'b0, rnd[48:30]})
			: ogru_pkg::cell_t'({2'b00, prod_s1[47:30]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			conv_s1 <= 1'b0;
		else
			conv_s1 <= cmd.conv;
	end

	ogru_pkg::cell_t x0_q, y0_q, x1_q, y1_q;

	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			prod_s1 <= conv_mag[31:0] * cpm_q;
			neg_s1  <= conv_e[33];
			sel_s1  <= cmd.conv_sel;
		end
		if (conv_s1) begin
			case (sel_s1)
				2'd0:    x0_q <= conv_cell;
				2'd1:    y0_q <= conv_cell;
				2'd2:    x1_q <= conv_cell;
				default: y1_q <= conv_cell;
			endcase
		end
	end

	// grid helpers
	function automatic logic in_grid(input ogru_pkg::cell_t x, input ogru_pkg::cell_t y);
		return (x >= 0) && (x < $signed(CW'(GRID_WIDTH)))
			&& (y >= 0) && (y < $signed(CW'(GRID_HEIGHT)));
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
		input logic [XW-1:0] x);
		return AW'(AW'(y) * AW'(GRID_WIDTH) + AW'(x));
	endfunction

	// line walker
	ogru_pkg::cell_t cx_q, cy_q;
	ogru_pkg::err_t  dx_q, dy_q, err_q;
	logic            sx_neg_q, sy_neg_q, mark_ok_q;
	logic signed [CW:0] ddx, ddy;
	ogru_pkg::err_t  e2, err_nxt;
	logic            step_x, step_y, at_end, cur_in;

	always_comb begin
		ddx     = (CW+1)'(x1_q) - (CW+1)'(x0_q);
		ddy     = (CW+1)'(y1_q) - (CW+1)'(y0_q);
		e2      = err_q <<< 1;
		step_x  = e2 > -dy_q;
		step_y  = e2 < dx_q;
		err_nxt = err_q - (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
		at_end  = (cx_q == x1_q) && (cy_q == y1_q);
		cur_in  = in_grid(cx_q, cy_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			dx_q      <= ddx[CW] ? EW'(-ddx) : EW'(ddx);
			dy_q      <= ddy[CW] ? EW'(-ddy) : EW'(ddy);
			err_q     <= (ddx[CW] ? EW'(-ddx) : EW'(ddx)) - (ddy[CW] ? EW'(-ddy) : EW'(ddy));
			sx_neg_q  <= !(x0_q < x1_q);
			sy_neg_q  <= !(y0_q < y1_q);
			cx_q      <= x0_q;
			cy_q      <= y0_q;
			mark_ok_q <= ({1'b0, range_q} + ogru_pkg::MARGIN_MM < {1'b0, rmax_q})
				&& in_grid(x1_q, y1_q);
		end else if (cmd.walk && !at_end) begin
			err_q <= err_nxt;
			if (step_x)
				cx_q <= sx_neg_q ? cx_q - 1'b1 : cx_q + 1'b1;
			if (step_y)
				cy_q <= sy_neg_q ? cy_q - 1'b1 : cy_q + 1'b1;
		end
	end

	// clearing pass counters
	logic [XW-1:0] clr_x_q;
	logic [YW-1:0] clr_y_q;
	logic          clr_x_last, clr_y_last, clr_free;

	assign clr_x_last = clr_x_q == XW'(GRID_WIDTH - 1);
	assign clr_y_last = clr_y_q == YW'(GRID_HEIGHT - 1);
	assign clr_free   = (32'(clr_x_q) >= FX_LO) && (32'(clr_x_q) <= FX_HI)
		&& (32'(clr_y_q) >= FY_LO) && (32'(clr_y_q) <= FY_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_x_q <= '0;
			clr_y_q <= '0;
		end else if (cmd.clear) begin
			if (clr_x_last) begin
				clr_x_q <= '0;
				clr_y_q <= clr_y_q + 1'b1;
			end else begin
				clr_x_q <= clr_x_q + 1'b1;
			end
		end
	end

	// pending read-modify-write of a walked cell
	logic          pend_s1;
	logic [AW-1:0] pend_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_s1 <= 1'b0;
		else
			pend_s1 <= cmd.walk && cur_in;
	end

	// grid memory, one write and one registered read a cycle
	logic [1:0]    grid_q [DEPTH];
	logic [1:0]    rd_q;
	logic          rd_in_q;
	logic          we, re;
	logic [AW-1:0] wa, ra;
	logic [1:0]    wd;
	logic          rd_item_in;

	assign rd_item_in = (32'(rdx_q) < GRID_WIDTH) && (32'(rdy_q) < GRID_HEIGHT);

	always_comb begin
		we = 1'b0;
		wa = pend_addr_s1;
		wd = ogru_pkg::CELL_FREE;
		if (cmd.clear) begin
			we = 1'b1;
			wa = cell_addr(clr_y_q, clr_x_q);
			wd = clr_free ? ogru_pkg::CELL_FREE : ogru_pkg::CELL_UNKNOWN;
		end else if (cmd.mark && mark_ok_q) begin
			we = 1'b1;
			wa = cell_addr(y1_q[YW-1:0], x1_q[XW-1:0]);
			wd = ogru_pkg::CELL_OCCUPIED;
		end else if (pend_s1 && rd_q == ogru_pkg::CELL_UNKNOWN) begin
			we = 1'b1;
		end
		re = (cmd.walk && cur_in) || (cmd.read && rd_item_in);
		ra = cmd.read ? cell_addr(YW'(rdy_q), XW'(rdx_q))
			: cell_addr(cy_q[YW-1:0], cx_q[XW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (we)
			grid_q[wa] <= wd;
		if (re)
			rd_q <= grid_q[ra];
		if (cmd.walk)
			pend_addr_s1 <= ra;
		if (cmd.read)
			rd_in_q <= rd_item_in;
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_value      <= (func_q && rd_in_q) ? rd_q : ogru_pkg::CELL_UNKNOWN;
			ray_used        <= !func_q && ray_ok;
			endpoint_marked <= !func_q && ray_ok && mark_ok_q;
		end
	end

	assign sts.is_read    = func_q;
	assign sts.ray_ok     = ray_ok;
	assign sts.at_end     = at_end;
	assign sts.clear_last = clr_x_last && clr_y_last;

endmodule

### rtl/ogru_ctrl.sv
// ----------------------------------------------------------------------------
// ogru_ctrl
// Sequencer: clearing pass, ray steps, cell read and output handshake.
// ----------------------------------------------------------------------------
module ogru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  ogru_pkg::ogru_sts_t sts,
	output ogru_pkg::ogru_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ANGLE, S_SINE, S_ENDPT, S_CONV, S_INIT,
		S_WALK, S_MARK, S_READ, S_RDWAIT, S_DONE
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       out_free;

	assign item_ready = state_q == S_IDLE;
	assign out_free   = !result_valid || result_ready;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = item_ready && item_valid;
		cmd.angle    = state_q == S_ANGLE;
		cmd.sine     = state_q == S_SINE;
		cmd.endpt    = state_q == S_ENDPT;
		cmd.conv     = (state_q == S_CONV) && (cnt_q < 3'd4);
		cmd.conv_sel = cnt_q[1:0];
		cmd.init     = state_q == S_INIT;
		cmd.walk     = state_q == S_WALK;
		cmd.mark     = state_q == S_MARK;
		cmd.read     = state_q == S_READ;
		cmd.clear    = state_q == S_CLEAR;
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid)
						state_q <= S_ANGLE;
				end
				S_ANGLE: begin
					if (sts.is_read)
						state_q <= S_READ;
					else if (!sts.ray_ok)
						state_q <= S_DONE;
					else
						state_q <= S_SINE;
				end
				S_SINE:  state_q <= S_ENDPT;
				S_ENDPT: begin
					cnt_q   <= '0;
					state_q <= S_CONV;
				end
				S_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4)
						state_q <= S_INIT;
				end
				S_INIT: state_q <= S_WALK;
				S_WALK: begin
					if (sts.at_end)
						state_q <= S_MARK;
				end
				S_MARK:   state_q <= S_DONE;
				S_READ:   state_q <= S_RDWAIT;
				S_RDWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occupancy grid ray update testbench
// Drives rays and cell reads into the grid block and checks every result
// against a behavioral copy of the grid kept in a scoreboard class. Runs the
// register settings through defaults, extremes and random values, with
// random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		bit        func;
		bit [11:0] beam;
		bit [15:0] range_mm;
		bit        range_ok;
		bit [9:0]  rx;
		bit [9:0]  ry;
	} grid_op_t;

	typedef struct {
		bit [1:0] cell_val;
		bit       used;
		bit       marked;
	} grid_res_t;

	localparam int GW = ogru_pkg::GRID_WIDTH_DEF;
	localparam int GH = ogru_pkg::GRID_HEIGHT_DEF;
	localparam int FH = ogru_pkg::FREE_HALF;

	// behavioral grid with its register copy and pending results
	class grid_scoreboard;
		bit [1:0]  cells [];
		bit [15:0] regs [8];
		grid_res_t pending [$];
		int        errors;
		int        n_reads, n_used, n_marked;
		longint    last_x, last_y;

		function new();
			cells = new[GW * GH];
			foreach (cells[i]) cells[i] = ogru_pkg::CELL_UNKNOWN;
			for (int y = GH / 2 - FH; y <= GH / 2 + FH; y++)
				for (int x = GW / 2 - FH; x <= GW / 2 + FH; x++)
					cells[y * GW + x] = ogru_pkg::CELL_FREE;
			regs[ogru_pkg::REG_CELLS_PER_MM] = ogru_pkg::RST_CELLS_PER_MM;
			regs[ogru_pkg::REG_ROBOT_X]      = ogru_pkg::RST_ROBOT_X;
			regs[ogru_pkg::REG_ROBOT_Y]      = ogru_pkg::RST_ROBOT_Y;
			regs[ogru_pkg::REG_HEADING]      = ogru_pkg::RST_HEADING;
			regs[ogru_pkg::REG_ANGLE_START]  = ogru_pkg::RST_ANGLE_START;
			regs[ogru_pkg::REG_ANGLE_STEP]   = ogru_pkg::RST_ANGLE_STEP;
			regs[ogru_pkg::REG_RANGE_MIN]    = ogru_pkg::RST_RANGE_MIN;
			regs[ogru_pkg::REG_RANGE_MAX]    = ogru_pkg::RST_RANGE_MAX;
			last_x = GW / 2;
			last_y = GH / 2;
		endfunction

		// table sine with rounded interpolation, Q14
		function int sin_q14(bit [15:0] a);
			int p, idx, frac, v, lo, hi;
			p = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
			idx = p >> 9;
			frac = p & 511;
			if (idx >= 32) begin
				v = 16384;
			end else begin
				lo = ogru_pkg::SINE_Q14[idx];
				hi = ogru_pkg::SINE_Q14[idx + 1];
				v = lo + (((hi - lo) * frac + 256) >> 9);
			end
			return a[15] ? -v : v;
		endfunction

		// floor of a Q14 millimetre value times cells per mm
		function longint mm_to_cell(longint e);
			longint prod;
			prod = e * longint'(regs[ogru_pkg::REG_CELLS_PER_MM]);
			return prod >>> 30;
		endfunction

		function bit on_grid(longint x, longint y);
			return x >= 0 && x < GW && y >= 0 && y < GH;
		endfunction

		function void clear_line(longint x0, longint y0, longint x1, longint y1);
			longint dx, dy, sx, sy, err, x, y, e2;
			dx = x1 > x0 ? x1 - x0 : x0 - x1;
			dy = y1 > y0 ? y1 - y0 : y0 - y1;
			sx = x0 < x1 ? 1 : -1;
			sy = y0 < y1 ? 1 : -1;
			err = dx - dy;
			x = x0;
			y = y0;
			forever begin
				if (on_grid(x, y) && cells[y * GW + x] == ogru_pkg::CELL_UNKNOWN)
					cells[y * GW + x] = ogru_pkg::CELL_FREE;
				if (x == x1 && y == y1) break;
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					x += sx;
				end
				if (e2 < dx) begin
					err += dx;
					y += sy;
				end
			end
		endfunction

		// accepted input transaction: update the grid, queue the result
		function void note_item(grid_op_t op);
			grid_res_t r;
			bit [15:0] ang;
			longint px, py, ex, ey, x0, y0, x1, y1;
			r = '{default: 0};
			if (op.func) begin
				n_reads++;
				r.cell_val = cells[op.ry * GW + op.rx];
			end else if (op.range_ok && op.range_mm >= regs[ogru_pkg::REG_RANGE_MIN] &&
					op.range_mm <= regs[ogru_pkg::REG_RANGE_MAX]) begin
				r.used = 1;
				n_used++;
				ang = regs[ogru_pkg::REG_HEADING] + regs[ogru_pkg::REG_ANGLE_START] +
					16'(op.beam * regs[ogru_pkg::REG_ANGLE_STEP]);
				px = longint'(regs[ogru_pkg::REG_ROBOT_X]) * 16384;
				py = longint'(regs[ogru_pkg::REG_ROBOT_Y]) * 16384;
				ex = px + longint'(op.range_mm) * sin_q14(ang + 16'd16384);
				ey = py + longint'(op.range_mm) * sin_q14(ang);
				x0 = mm_to_cell(px);
				y0 = mm_to_cell(py);
				x1 = mm_to_cell(ex);
				y1 = mm_to_cell(ey);
				clear_line(x0, y0, x1, y1);
				if (int'(op.range_mm) + 100 < int'(regs[ogru_pkg::REG_RANGE_MAX]) &&
						on_grid(x1, y1)) begin
					cells[y1 * GW + x1] = ogru_pkg::CELL_OCCUPIED;
					r.marked = 1;
					n_marked++;
				end
				if (on_grid(x1, y1)) begin
					last_x = x1;
					last_y = y1;
				end
			end
			pending.push_back(r);
		endfunction

		// accepted output transaction against the oldest expectation
		function void check_result(grid_res_t act);
			grid_res_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result cell=%0d used=%0d marked=%0d",
						act.cell_val, act.used, act.marked);
				return;
			end
			exp_r = pending.pop_front();
			if (act.cell_val !== exp_r.cell_val || act.used !== exp_r.used ||
					act.marked !== exp_r.marked) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
						exp_r.cell_val, exp_r.used, exp_r.marked,
						act.cell_val, act.used, act.marked);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	ogru_item_if   item_ch ();
	ogru_result_if result_ch ();

	occupancy_grid_ray_update DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	grid_scoreboard sb;
	int snd_idle;
	int rcv_idle;
	bit hold_req;
	int hold_left;

	// clock
	always #5 clk = ~clk;

	// run limit
	initial begin
		#100_000_000;
		$display("testbench failed");
		$finish;
	end

	// receiver ready with random idling and requested hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// result sampling
	always @(posedge clk) begin
		grid_res_t act;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			act.cell_val = result_ch.cell_value;
			act.used = result_ch.ray_used;
			act.marked = result_ch.endpoint_marked;
			sb.check_result(act);
		end
	end

	// offer one transaction, called and returning at a falling edge
	task automatic push_item(grid_op_t op);
		while ($urandom_range(99) < snd_idle) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.func        <= op.func;
		item_ch.beam_index  <= op.beam;
		item_ch.range_mm    <= op.range_mm;
		item_ch.range_valid <= op.range_ok;
		item_ch.read_x      <= op.rx;
		item_ch.read_y      <= op.ry;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(op);
		@(negedge clk);
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// write all eight registers while idle
	task automatic load_regs(bit [15:0] v [8]);
		for (int i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= 3'(i);
			wr_data  <= v[i];
			sb.regs[i] = v[i];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic grid_op_t ray_op(bit [11:0] beam, bit [15:0] rng, bit ok);
		grid_op_t op;
		op = '{default: 0};
		op.beam = beam;
		op.range_mm = rng;
		op.range_ok = ok;
		op.rx = 10'($urandom);
		op.ry = 10'($urandom);
		return op;
	endfunction

	function automatic grid_op_t read_op(int x, int y);
		grid_op_t op;
		op = ray_op(12'($urandom), 16'($urandom), 1'($urandom));
		op.func = 1;
		op.rx = 10'(x);
		op.ry = 10'(y);
		return op;
	endfunction

	// random mix: mostly in-range rays and reads near recent endpoints
	task automatic random_items(int n);
		int sel;
		int lo, hi;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			lo = sb.regs[ogru_pkg::REG_RANGE_MIN];
			hi = sb.regs[ogru_pkg::REG_RANGE_MAX];
			if (sel < 20)
				push_item(read_op(int'(sb.last_x) + $urandom_range(6) - 3,
					int'(sb.last_y) + $urandom_range(6) - 3));
			else if (sel < 30)
				push_item(read_op($urandom_range(1023), $urandom_range(1023)));
			else if (sel < 35)
				push_item(read_op(GW / 2 + $urandom_range(30) - 15,
					GH / 2 + $urandom_range(30) - 15));
			else if (sel < 85 && hi >= lo)
				push_item(ray_op(12'($urandom), 16'($urandom_range(hi, lo)), 1'b1));
			else
				push_item(ray_op(12'($urandom), 16'($urandom), 1'($urandom)));
		end
	endtask

	initial begin
		bit [15:0] cfg [8];
		int rmax;
		clk = 0;
		arst_n = 0;
		wr_en = 0;
		wr_index = 0;
		wr_data = 0;
		item_ch.valid = 0;
		item_ch.func = 0;
		item_ch.beam_index = 0;
		item_ch.range_mm = 0;
		item_ch.range_valid = 0;
		item_ch.read_x = 0;
		item_ch.read_y = 0;
		result_ch.ready = 0;
		hold_req = 0;
		hold_left = 0;
		sb = new();
		snd_idle = 13;
		rcv_idle = 50;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed checks at reset settings
		push_item(read_op(0, 0));
		push_item(read_op(1023, 1023));
		push_item(read_op(GW / 2 - FH, GH / 2 + FH));
		push_item(read_op(GW / 2 - FH - 1, GH / 2));
		push_item(ray_op(12'd0, 16'd5000, 1'b0));
		push_item(ray_op(12'd0, 16'd99, 1'b1));
		push_item(ray_op(12'd0, 16'd10001, 1'b1));
		push_item(ray_op(12'd0, 16'hFFFF, 1'b1));
		push_item(ray_op(12'd0, 16'd100, 1'b1));
		push_item(ray_op(12'd90, 16'd10000, 1'b1));
		push_item(ray_op(12'd180, 16'd9900, 1'b1));
		push_item(ray_op(12'd270, 16'd9899, 1'b1));
		push_item(read_op(int'(sb.last_x), int'(sb.last_y)));
		push_item(ray_op(12'd4095, 16'd5000, 1'b1));
		push_item(read_op(int'(sb.last_x), int'(sb.last_y)));
		push_item(read_op(int'(sb.last_x) - 1, int'(sb.last_y)));
		push_item(ray_op(12'd45, 16'd3000, 1'b1));
		push_item(read_op(int'(sb.last_x), int'(sb.last_y)));
		drain();

		// long output hold-off while items keep coming
		@(posedge clk);
		hold_req = 1;
		@(negedge clk);
		random_items(70);
		drain();

		// fine cells, all-ones heading and step, robot near the center
		cfg = '{16'd65535, 16'd512, 16'd512, 16'hFFFF, 16'h8000, 16'hFFFF, 16'd0, 16'd400};
		load_regs(cfg);
		random_items(60);
		drain();

		// coarsest cells, robot at the far corner, widest range window
		snd_idle = 50;
		rcv_idle = 13;
		cfg = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd16384, 16'd0, 16'd1, 16'd0, 16'hFFFF};
		load_regs(cfg);
		random_items(40);
		drain();

		// robot at origin, maximum too short for any endpoint
		cfg = '{16'd2000, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd91, 16'd0, 16'd50};
		load_regs(cfg);
		random_items(30);
		drain();

		// random moderate settings
		snd_idle = 0;
		rcv_idle = 0;
		for (int k = 0; k < 3; k++) begin
			rmax = $urandom_range(20000, 1000);
			cfg[ogru_pkg::REG_CELLS_PER_MM] = 16'($urandom_range(4000, 1000));
			cfg[ogru_pkg::REG_ROBOT_X]      = 16'($urandom_range(40000, 10000));
			cfg[ogru_pkg::REG_ROBOT_Y]      = 16'($urandom_range(40000, 10000));
			cfg[ogru_pkg::REG_HEADING]      = 16'($urandom);
			cfg[ogru_pkg::REG_ANGLE_START]  = 16'($urandom);
			cfg[ogru_pkg::REG_ANGLE_STEP]   = 16'($urandom);
			cfg[ogru_pkg::REG_RANGE_MIN]    = 16'($urandom_range(300));
			cfg[ogru_pkg::REG_RANGE_MAX]    = 16'(rmax);
			load_regs(cfg);
			random_items(45);
			drain();
		end

		// back to reset values
		cfg = '{ogru_pkg::RST_CELLS_PER_MM, ogru_pkg::RST_ROBOT_X, ogru_pkg::RST_ROBOT_Y,
			ogru_pkg::RST_HEADING, ogru_pkg::RST_ANGLE_START, ogru_pkg::RST_ANGLE_STEP,
			ogru_pkg::RST_RANGE_MIN, ogru_pkg::RST_RANGE_MAX};
		load_regs(cfg);
		random_items(50);
		drain();
		repeat (50) @(negedge clk);

		$display("covered %0d reads, %0d rays used, %0d endpoints marked over 8 settings",
			sb.n_reads, sb.n_used, sb.n_marked);
		$display("mismatches: %0d, results left waiting: %0d", sb.errors, sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
